// ----- src/periodic_interrupt_timer_regs_unit_defines.svh -----
// ----------------------------------------------------------------------------
// periodic interrupt timer assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PERIODIC_INTERRUPT_TIMER_REGS_UNIT_DEFINES_SVH
`define PERIODIC_INTERRUPT_TIMER_REGS_UNIT_DEFINES_SVH

// same-cycle implication
`define PITR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pitr: same-cycle check failed");

// next-cycle implication
`define PITR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pitr: next-cycle check failed");

`endif

// ----- src/pitr_pkg.sv -----
// ----------------------------------------------------------------------------
// pitr_pkg
// types, codes and defaults of the periodic interrupt timer
// ----------------------------------------------------------------------------
`default_nettype none

package pitr_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam int KIND_W = 2;
	localparam int SEL_W  = 3;
	localparam int CHAN_W = 2;
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_IDLE  = 2'd3
	} kind_t;

	typedef enum logic [SEL_W-1:0] {
		REG_CTRL   = 3'd0,
		REG_IRQ_EN = 3'd1,
		REG_FLAGS  = 3'd2,
		REG_START  = 3'd3,
		REG_STOP   = 3'd4,
		REG_RELOAD = 3'd5,
		REG_COUNT  = 3'd6,
		REG_MODE   = 3'd7
	} reg_sel_t;

	// control bit positions
	localparam int CTRL_EN_BIT  = 0;
	localparam int CTRL_RST_BIT = 1;

	// per-channel update strobes, already qualified with the stage advance
	typedef struct packed {
		logic clear;
		logic tick;
		logic start;
		logic stop;
		logic flag_clr;
		logic reload_wr;
		logic mode_wr;
	} chan_cmd_t;

	typedef struct packed {
		logic running;
		logic flag;
		logic flag_next;
	} chan_stat_t;

endpackage

`default_nettype wire

// ----- src/pitr_if.sv -----
// ----------------------------------------------------------------------------
// pitr channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pitr_cmd_if import pitr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SEL_W-1:0]    reg_select;
	logic [CHAN_W-1:0]   channel;
	logic [DATA_W-1:0]   write_data;

	modport source (output valid, output kind, output reg_select, output channel,
		output write_data, input ready);
	modport sink (input valid, input kind, input reg_select, input channel,
		input write_data, output ready);
endinterface

interface pitr_rsp_if import pitr_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) ();
	logic                    valid;
	logic                    ready;
	logic [DATA_W-1:0]       read_data;
	logic [NUM_CHANNELS-1:0] interrupt_lines;

	modport source (output valid, output read_data, output interrupt_lines, input ready);
	modport sink (input valid, input read_data, input interrupt_lines, output ready);
endinterface

`default_nettype wire

// ----- src/pitr_chan.sv -----
// ----------------------------------------------------------------------------
// pitr_chan
// one timer channel: reload, down counter, mode, run bit and timeout flag
// ----------------------------------------------------------------------------
`default_nettype none

module pitr_chan import pitr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire chan_cmd_t              cmd,
	input  wire logic [COUNT_WIDTH-1:0] wdata,
	input  wire logic [MODE_W-1:0]      mode_wdata,
	output chan_stat_t                  stat,
	output logic [COUNT_WIDTH-1:0]      reload,
	output logic [COUNT_WIDTH-1:0]      count,
	output logic [MODE_W-1:0]           mode
);

	logic [COUNT_WIDTH-1:0] reload_q, reload_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [MODE_W-1:0]      mode_q, mode_d;
	logic                   running_q, running_d;
	logic                   flag_q, flag_d;

	always_comb begin
		reload_d  = reload_q;
		count_d   = count_q;
		mode_d    = mode_q;
		running_d = running_q;
		flag_d    = flag_q;
		if (cmd.clear) begin
			reload_d  = '0;
			count_d   = '0;
			mode_d    = '0;
			running_d = 1'b0;
			flag_d    = 1'b0;
		end else begin
			if (cmd.reload_wr) begin
				reload_d = wdata;
			end
			if (cmd.mode_wr) begin
				mode_d = mode_wdata;
			end
			// only a stopped channel reloads on start
			if (cmd.start && !running_q) begin
				running_d = 1'b1;
				count_d   = reload_q;
			end
			if (cmd.stop) begin
				running_d = 1'b0;
			end
			if (cmd.flag_clr) begin
				flag_d = 1'b0;
			end
			if (cmd.tick && running_q) begin
				if (count_q == '0) begin
					flag_d  = 1'b1;
					count_d = reload_q;
				end else begin
					count_d = count_q - COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= '0;
			count_q   <= '0;
			mode_q    <= '0;
			running_q <= 1'b0;
			flag_q    <= 1'b0;
		end else begin
			reload_q  <= reload_d;
			count_q   <= count_d;
			mode_q    <= mode_d;
			running_q <= running_d;
			flag_q    <= flag_d;
		end
	end

	assign stat.running   = running_q;
	assign stat.flag      = flag_q;
	assign stat.flag_next = flag_d;
	assign reload         = reload_q;
	assign count          = count_q;
	assign mode           = mode_q;

endmodule

`default_nettype wire

// ----- src/periodic_interrupt_timer_regs_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_interrupt_timer_regs_unit
// multi-channel periodic interrupt timer with its register file
// ----------------------------------------------------------------------------
// Each transfer on cmd is a timer tick, a register read, a register write or
// an idle code; each one yields exactly one transfer on rsp carrying the read
// data (zero for ticks, writes and idle codes) and the interrupt lines as they
// stand after that item. The block takes one item every clock cycle while
// results are taken: a transfer is captured in an input register, then
// applied to the channel state and the global registers as the result
// register is loaded. The rate is set by the state update of the channel
// counters; cmd.ready drops only while a result waits in the result register
// and the input register is also full.
// A running channel with reload value R raises its timeout flag every R+1
// ticks, as long as the module is enabled and not held in soft reset.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_interrupt_timer_regs_unit import pitr_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pitr_cmd_if.sink  cmd,
	pitr_rsp_if.source rsp
);

	// input register
	logic              valid_s1;
	kind_t             kind_s1;
	reg_sel_t          sel_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [DATA_W-1:0] wdata_s1;

	// result register
	logic                    valid_s2;
	logic [DATA_W-1:0]       read_data_s2;
	logic [NUM_CHANNELS-1:0] irq_s2;

	// global registers
	logic                    enable_q;
	logic                    soft_rst_q;
	logic [NUM_CHANNELS-1:0] irq_mask_q, irq_mask_d;

	logic advance;
	logic wr_ctrl, wr_other, do_clear, do_tick;

	chan_cmd_t              chan_cmd    [NUM_CHANNELS];
	chan_stat_t             chan_stat   [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] chan_reload [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] chan_count  [NUM_CHANNELS];
	logic [MODE_W-1:0]      chan_mode   [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] running_vec, flag_vec, flag_next_vec;
	logic [DATA_W-1:0]       read_mux;

	// the item in the input register is applied when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1  <= kind_t'(cmd.kind);
			sel_s1   <= reg_sel_t'(cmd.reg_select);
			chan_s1  <= cmd.channel;
			wdata_s1 <= cmd.write_data;
		end
	end

	// decode: control writes always land, other writes are blocked by soft reset
	assign wr_ctrl  = advance && (kind_s1 == KIND_WRITE) && (sel_s1 == REG_CTRL);
	assign wr_other = advance && (kind_s1 == KIND_WRITE) && !soft_rst_q;
	assign do_clear = wr_ctrl && wdata_s1[CTRL_RST_BIT];
	assign do_tick  = advance && (kind_s1 == KIND_TICK) && enable_q && !soft_rst_q;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			chan_cmd[i].clear     = do_clear;
			chan_cmd[i].tick      = do_tick;
			chan_cmd[i].start     = wr_other && (sel_s1 == REG_START) && wdata_s1[i];
			chan_cmd[i].stop      = wr_other && (sel_s1 == REG_STOP) && wdata_s1[i];
			chan_cmd[i].flag_clr  = wr_other && (sel_s1 == REG_FLAGS) && wdata_s1[i];
			chan_cmd[i].reload_wr = wr_other && (sel_s1 == REG_RELOAD)
				&& (32'(chan_s1) == i);
			chan_cmd[i].mode_wr   = wr_other && (sel_s1 == REG_MODE)
				&& (32'(chan_s1) == i);
		end
	end

	// one counter slice per channel
	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
		pitr_chan #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (chan_cmd[g]),
			.wdata      (wdata_s1[COUNT_WIDTH-1:0]),
			.mode_wdata (wdata_s1[MODE_W-1:0]),
			.stat       (chan_stat[g]),
			.reload     (chan_reload[g]),
			.count      (chan_count[g]),
			.mode       (chan_mode[g])
		);
		assign running_vec[g]   = chan_stat[g].running;
		assign flag_vec[g]      = chan_stat[g].flag;
		assign flag_next_vec[g] = chan_stat[g].flag_next;
	end

	// interrupt mask, cleared by soft reset
	always_comb begin
		irq_mask_d = irq_mask_q;
		if (do_clear) begin
			irq_mask_d = '0;
		end else if (wr_other && (sel_s1 == REG_IRQ_EN)) begin
			irq_mask_d = wdata_s1[NUM_CHANNELS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			soft_rst_q <= 1'b0;
			irq_mask_q <= '0;
		end else begin
			irq_mask_q <= irq_mask_d;
			if (wr_ctrl) begin
				enable_q   <= wdata_s1[CTRL_EN_BIT];
				soft_rst_q <= wdata_s1[CTRL_RST_BIT];
			end
		end
	end

	// read mux; channel registers read zero past the last channel
	always_comb begin
		read_mux = '0;
		if (kind_s1 == KIND_READ) begin
			unique case (sel_s1)
				REG_CTRL: begin
					read_mux[CTRL_EN_BIT]  = enable_q;
					read_mux[CTRL_RST_BIT] = soft_rst_q;
				end
				REG_IRQ_EN: read_mux = DATA_W'(irq_mask_q);
				REG_FLAGS:  read_mux = DATA_W'(flag_vec);
				REG_START:  read_mux = DATA_W'(running_vec);
				REG_STOP:   read_mux = '0;
				REG_RELOAD: begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (32'(chan_s1) == i) read_mux = DATA_W'(chan_reload[i]);
					end
				end
				REG_COUNT: begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (32'(chan_s1) == i) read_mux = DATA_W'(chan_count[i]);
					end
				end
				REG_MODE: begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (32'(chan_s1) == i) read_mux = DATA_W'(chan_mode[i]);
					end
				end
			endcase
		end
	end

	// result register: interrupt lines reflect state after this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= read_mux;
			irq_s2       <= flag_next_vec & irq_mask_d;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.read_data       = read_data_s2;
	assign rsp.interrupt_lines = irq_s2;

endmodule

`default_nettype wire

// ----- src/pitr_checker.sv -----
// ----------------------------------------------------------------------------
// pitr_checker
// port-level checks of the periodic interrupt timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_interrupt_timer_regs_unit_defines.svh"

module pitr_checker import pitr_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    cmd_valid,
	input wire logic                    cmd_ready,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire logic [DATA_W-1:0]       rsp_read_data,
	input wire logic [NUM_CHANNELS-1:0] rsp_interrupt_lines
);

	// a stalled result keeps its contents
	`PITR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_interrupt_lines))

	// an empty result register never blocks a new transfer
	`PITR_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !rsp_valid, cmd_ready)

	// with the sink ready, a transfer passes through the input and result registers to rsp
	`PITR_ASSERT_NEXT(a_latency, clk, arst_n, (cmd_valid && cmd_ready) ##1 rsp_ready, rsp_valid)

endmodule

bind periodic_interrupt_timer_regs_unit pitr_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_pitr_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cmd_valid           (cmd.valid),
	.cmd_ready           (cmd.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_read_data       (rsp.read_data),
	.rsp_interrupt_lines (rsp.interrupt_lines)
);

`default_nettype wire
